/* rtl/jsu_pkg.sv */
// Shared types and sizes for the JSON string unescaper.
package jsu_pkg;

    // Default number of entries in the queue between the front and back parts
    localparam int JSU_QUEUE_DEPTH = 4;

    // One input transfer: a byte of the string body and its end marker
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } jsu_in_t;

    // One output transfer
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       bad_escape;
    } jsu_out_t;

    // Work handed from the front to the back: up to three bytes to send
    typedef struct packed {
        logic [2:0][7:0] bytes;      // bytes[0] goes out first
        logic [1:0]      count;      // number of bytes to send, 1 to 3
        logic            last;       // string ends with the final byte
        logic            bad;        // error result (single zero byte)
    } jsu_cmd_t;

endpackage

/* rtl/jsu_front.sv */
// Front part: escape state machine that turns input bytes into output byte groups.
module jsu_front
    import jsu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  jsu_in_t  s_data,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output jsu_cmd_t cmd_data
);

    localparam logic [15:0] CP_ONE_MAX = 16'h007f;
    localparam logic [15:0] CP_TWO_MAX = 16'h07ff;
    localparam logic [7:0]  LEAD_TWO   = 8'hc0;
    localparam logic [7:0]  LEAD_THREE = 8'he0;
    localparam logic [7:0]  CONT_MARK  = 8'h80;
    localparam logic [7:0]  CONT_MASK  = 8'h3f;

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    localparam logic [1:0] HEX_LAST_DIGIT = 2'd3;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  seen_reg, seen_next;
    logic [11:0] part_reg, part_next;

    logic        accept;
    logic        emit;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cp;
    logic [7:0]  b;
    jsu_cmd_t    cmd;

    // Decode one hex digit of either case
    always_comb begin
        b       = s_data.in_byte;
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            hex_val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            hex_val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            hex_val = 4'(b - 8'h37);
        end else begin
            hex_ok  = 1'b0;
        end
    end

    assign cp = {part_reg, hex_val};

    // Step the escape state machine and build the byte group
    always_comb begin
        mode_next = mode_reg;
        seen_next = seen_reg;
        part_next = part_reg;
        emit      = 1'b0;
        cmd.bytes = '0;
        cmd.count = 2'd1;
        cmd.last  = s_data.in_last;
        cmd.bad   = 1'b0;
        unique case (mode_reg)
            MODE_ESCAPE: begin
                if (b == CH_U) begin
                    if (s_data.in_last) begin
                        emit = 1'b1;
                        cmd.bad = 1'b1;
                        mode_next = MODE_NORMAL;
                    end else begin
                        mode_next = MODE_HEX;
                    end
                    seen_next = '0;
                    part_next = '0;
                end else begin
                    emit = 1'b1;
                    unique case (b)
                        CH_B:    cmd.bytes[0] = 8'h08;
                        CH_F:    cmd.bytes[0] = 8'h0c;
                        CH_N:    cmd.bytes[0] = 8'h0a;
                        CH_R:    cmd.bytes[0] = 8'h0d;
                        CH_T:    cmd.bytes[0] = 8'h09;
                        default: cmd.bytes[0] = b;
                    endcase
                    mode_next = MODE_NORMAL;
                    seen_next = '0;
                    part_next = '0;
                end
            end
            MODE_HEX: begin
                if (!hex_ok || (seen_reg != HEX_LAST_DIGIT && s_data.in_last)) begin
                    // Bad digit or escape cut short: one error result
                    emit = 1'b1;
                    cmd.bad = 1'b1;
                    mode_next = MODE_NORMAL;
                    seen_next = '0;
                    part_next = '0;
                end else if (seen_reg != HEX_LAST_DIGIT) begin
                    part_next = {part_reg[7:0], hex_val};
                    seen_next = seen_reg + 2'd1;
                end else begin
                    // Fourth digit: encode the code point as UTF-8
                    emit = 1'b1;
                    if (cp <= CP_ONE_MAX) begin
                        cmd.count    = 2'd1;
                        cmd.bytes[0] = cp[7:0];
                    end else if (cp <= CP_TWO_MAX) begin
                        cmd.count    = 2'd2;
                        cmd.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
                        cmd.bytes[1] = CONT_MARK | ({2'b00, cp[5:0]} & CONT_MASK);
                    end else begin
                        cmd.count    = 2'd3;
                        cmd.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
                        cmd.bytes[1] = CONT_MARK | ({2'b00, cp[11:6]} & CONT_MASK);
                        cmd.bytes[2] = CONT_MARK | ({2'b00, cp[5:0]} & CONT_MASK);
                    end
                    mode_next = MODE_NORMAL;
                    seen_next = '0;
                    part_next = '0;
                end
            end
            default: begin
                // Normal mode, also taken by the unused code
                if (b == CH_BSLASH) begin
                    if (s_data.in_last) begin
                        emit = 1'b1;
                        cmd.bad = 1'b1;
                        mode_next = MODE_NORMAL;
                    end else begin
                        mode_next = MODE_ESCAPE;
                    end
                end else begin
                    emit = 1'b1;
                    cmd.bytes[0] = b;
                    mode_next = MODE_NORMAL;
                end
                seen_next = '0;
                part_next = '0;
            end
        endcase
    end

    // Stall input only while the queue is full
    assign s_ready   = cmd_ready;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = accept && emit;
    assign cmd_data  = cmd;

    // Hold decoder state, advance on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            seen_reg <= '0;
            part_reg <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            seen_reg <= seen_next;
            part_reg <= part_next;
        end
    end

endmodule

/* rtl/jsu_queue.sv */
// Small register queue of byte groups between the front and back parts.
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = JSU_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  jsu_cmd_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output jsu_cmd_t pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [PW-1:0] PTR_ONE = PW'(1);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    jsu_cmd_t       mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  cnt_reg;
    logic           do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Write the entry at the tail
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + PTR_ONE;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + PTR_ONE;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CNT_ONE;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CNT_ONE;
            end
        end
    end

endmodule

/* rtl/jsu_back.sv */
// Back part: sends the bytes of each queued group one transfer at a time.
module jsu_back
    import jsu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  jsu_cmd_t cmd_data,
    output logic     m_valid,
    input  logic     m_ready,
    output jsu_out_t m_data
);

    jsu_cmd_t   cur_reg;
    logic       cur_valid_reg;
    logic [1:0] pos_reg;
    logic       at_end;
    logic       load;

    assign at_end    = (pos_reg == cur_reg.count - 2'd1);
    assign load      = !cur_valid_reg || (m_ready && at_end);
    assign cmd_ready = load;

    // Present the current byte from the held group
    assign m_valid           = cur_valid_reg;
    assign m_data.out_byte   = cur_reg.bytes[pos_reg];
    assign m_data.out_last   = cur_reg.last && at_end;
    assign m_data.bad_escape = cur_reg.bad;

    // Load a new group when the current one is done, else step through it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else if (load) begin
            cur_valid_reg <= cmd_valid;
            pos_reg       <= '0;
        end else if (m_ready) begin
            pos_reg       <= pos_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && cmd_valid) begin
            cur_reg <= cmd_data;
        end
    end

endmodule

/* rtl/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper with UTF-8 output.
//
// Input channel s_*: one body byte of a quoted string per transfer, quotes
// stripped, with in_last on the final byte. Output channel m_*: decoded
// bytes; \b \f \n \r \t give control bytes, other escaped bytes pass as
// they are, and \uXXXX gives one to three UTF-8 bytes. A bad hex digit or
// an escape cut off by the end of the string gives one zero byte with
// bad_escape set. out_last marks the final byte produced by the final input.
//
// Throughput: one input byte per cycle while the queue has room and one
// output byte per cycle while m_ready is high; a \u escape giving two or
// three bytes holds the single back-part output port for one transfer per
// byte. Each input is registered in the queue and then in the back part.
// A queue of QUEUE_DEPTH byte groups sits between the decoder and the
// output stage, so input keeps flowing while the receiver stalls until the
// queue fills; then s_ready drops.
// Reset (aresetn low, synchronous) empties the queue and returns the
// decoder to normal mode.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  jsu_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output jsu_out_t m_data
);

    logic     push_valid, push_ready;
    jsu_cmd_t push_data;
    logic     pop_valid, pop_ready;
    jsu_cmd_t pop_data;

    jsu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (push_valid),
        .cmd_ready (push_ready),
        .cmd_data  (push_data)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    jsu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* verif/jsu_tb_pkg.sv */
// Character codes shared by the unescaper testbench and its checker.
package jsu_tb_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;

    // Control bytes produced by the short escapes
    localparam logic [7:0] CTL_BACKSPACE = 8'h08;
    localparam logic [7:0] CTL_FORMFEED  = 8'h0C;
    localparam logic [7:0] CTL_NEWLINE   = 8'h0A;
    localparam logic [7:0] CTL_RETURN    = 8'h0D;
    localparam logic [7:0] CTL_TAB       = 8'h09;

endpackage

/* verif/json_string_unescape_utf8_checker.sv */
// Checker for the unescaper: predicts output bytes from input transfers and compares them.
module json_string_unescape_utf8_checker
    import jsu_pkg::*;
    import jsu_tb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  jsu_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  jsu_out_t m_data,
    output int       fail_count,
    output int       pending,
    output int       bytes_checked,
    output int       errors_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        DEC_NORMAL = 2'd0,
        DEC_ESCAPE = 2'd1,
        DEC_HEX    = 2'd2
    } dec_mode_e;

    localparam logic [15:0] CP_ONE_BYTE_MAX = 16'h007F;
    localparam logic [15:0] CP_TWO_BYTE_MAX = 16'h07FF;
    localparam logic [7:0]  LEAD_TWO        = 8'hC0;
    localparam logic [7:0]  LEAD_THREE      = 8'hE0;
    localparam logic [7:0]  CONT_MARK       = 8'h80;
    localparam logic [7:0]  CONT_MASK       = 8'h3F;

    dec_mode_e   dec_mode;
    logic [1:0]  digits_taken;
    logic [11:0] code_so_far;
    jsu_out_t    decoded_q[$];

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
        if (b >= CH_LOWER_A && b <= CH_LOWER_F) return int'(b - CH_LOWER_A) + 10;
        if (b >= CH_UPPER_A && b <= CH_UPPER_F) return int'(b - CH_UPPER_A) + 10;
        return -1;
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic last,
                                       input logic bad);
        jsu_out_t r;
        r.out_byte   = b;
        r.out_last   = last;
        r.bad_escape = bad;
        decoded_q.push_back(r);
    endfunction

    function automatic void back_to_normal();
        dec_mode     = DEC_NORMAL;
        digits_taken = '0;
        code_so_far  = '0;
    endfunction

    function automatic void queue_error(input logic last);
        queue_byte(8'h00, last, 1'b1);
        back_to_normal();
    endfunction

    // Work out the bytes that one input transfer gives
    function automatic void decode_byte(input jsu_in_t item);
        logic [7:0]  b;
        logic [7:0]  c;
        logic        last;
        int          d;
        logic [15:0] cp;
        b    = item.in_byte;
        last = item.in_last;
        case (dec_mode)
            DEC_ESCAPE: begin
                if (b == CH_U) begin
                    if (last) begin
                        queue_error(1'b1);
                    end else begin
                        dec_mode     = DEC_HEX;
                        digits_taken = '0;
                        code_so_far  = '0;
                    end
                end else begin
                    case (b)
                        CH_B:    c = CTL_BACKSPACE;
                        CH_F:    c = CTL_FORMFEED;
                        CH_N:    c = CTL_NEWLINE;
                        CH_R:    c = CTL_RETURN;
                        CH_T:    c = CTL_TAB;
                        default: c = b;
                    endcase
                    back_to_normal();
                    queue_byte(c, last, 1'b0);
                end
            end
            DEC_HEX: begin
                d = hex_nibble(b);
                if (d < 0) begin
                    queue_error(last);
                end else if (digits_taken < 2'd3) begin
                    if (last) begin
                        queue_error(1'b1);
                    end else begin
                        code_so_far  = {code_so_far[7:0], d[3:0]};
                        digits_taken = digits_taken + 2'd1;
                    end
                end else begin
                    cp = {code_so_far, d[3:0]};
                    back_to_normal();
                    if (cp <= CP_ONE_BYTE_MAX) begin
                        queue_byte(cp[7:0], last, 1'b0);
                    end else if (cp <= CP_TWO_BYTE_MAX) begin
                        queue_byte(LEAD_TWO | {3'b000, cp[10:6]}, 1'b0, 1'b0);
                        queue_byte(CONT_MARK | ({2'b00, cp[5:0]} & CONT_MASK), last, 1'b0);
                    end else begin
                        queue_byte(LEAD_THREE | {4'b0000, cp[15:12]}, 1'b0, 1'b0);
                        queue_byte(CONT_MARK | ({2'b00, cp[11:6]} & CONT_MASK), 1'b0, 1'b0);
                        queue_byte(CONT_MARK | ({2'b00, cp[5:0]} & CONT_MASK), last, 1'b0);
                    end
                end
            end
            default: begin
                // Normal mode, and the unused mode value
                if (b == CH_BACKSLASH) begin
                    if (last) begin
                        queue_error(1'b1);
                    end else begin
                        dec_mode     = DEC_ESCAPE;
                        digits_taken = '0;
                        code_so_far  = '0;
                    end
                end else begin
                    back_to_normal();
                    queue_byte(b, last, 1'b0);
                end
            end
        endcase
    endfunction

    // Compare output transfers first, then predict from input transfers
    always @(posedge aclk) begin
        jsu_out_t want;
        if (!aresetn) begin
            back_to_normal();
            decoded_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("output transfer with nothing expected: byte %h last %b bad %b",
                           m_data.out_byte, m_data.out_last, m_data.bad_escape);
                    fail_count = fail_count + 1;
                end else begin
                    want = decoded_q.pop_front();
                    bytes_checked = bytes_checked + 1;
                    if (want.bad_escape) errors_seen = errors_seen + 1;
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, m_data.out_byte);
                        fail_count = fail_count + 1;
                    end
                    if (m_data.out_last !== want.out_last) begin
                        $error("out_last: expected %b, got %b", want.out_last, m_data.out_last);
                        fail_count = fail_count + 1;
                    end
                    if (m_data.bad_escape !== want.bad_escape) begin
                        $error("bad_escape: expected %b, got %b",
                               want.bad_escape, m_data.bad_escape);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data);
            end
        end
        pending = decoded_q.size();
    end

endmodule

/* verif/json_string_unescape_utf8_tb.sv */
// Testbench top for the unescaper: clock, reset, string stimulus, receiver stalls and verdict.
module json_string_unescape_utf8_tb
    import jsu_pkg::*;
    import jsu_tb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] byte_q_t[$];

    localparam int RANDOM_BYTES = 200;
    localparam int DRAIN_EVERY  = 70;
    localparam int TAIL_CYCLES  = 20;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    jsu_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    jsu_out_t m_data;

    int fail_count;
    int pending;
    int bytes_checked;
    int errors_seen;

    int bytes_sent;
    int strings_sent;
    int burst_left;

    json_string_unescape_utf8 dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    json_string_unescape_utf8_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .bytes_checked (bytes_checked),
        .errors_seen   (errors_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: pick a new stall style each time the random run of the current one ends
    int       ready_style;
    int       style_left;
    bit [7:0] stall_tick;

    always @(posedge aclk) begin
        if (style_left == 0) begin
            ready_style <= $urandom_range(0, 3);
            style_left  <= $urandom_range(16, 96);
        end else begin
            style_left <= style_left - 1;
        end
        stall_tick <= stall_tick + 8'd1;
        case (ready_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= (stall_tick[1:0] == 2'd0);
            default: m_ready <= ((stall_tick % 7) < 3);
        endcase
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10) return CH_ZERO + 8'(n);
        return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
    endfunction

    // Append a \u escape for cp with digits in random case
    task automatic append_unicode(ref byte_q_t q, input logic [15:0] cp);
        q.push_back(CH_BACKSLASH);
        q.push_back(CH_U);
        for (int i = 3; i >= 0; i--) begin
            q.push_back(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))));
        end
    endtask

    // Send one byte, opening a random gap when the current burst runs out
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 10);
        end
        burst_left = burst_left - 1;
        s_valid        <= 1'b1;
        s_data.in_byte <= b;
        s_data.in_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_string(input byte_q_t q);
        for (int i = 0; i < q.size(); i++) begin
            send_byte(q[i], i == q.size() - 1);
        end
        strings_sent = strings_sent + 1;
    endtask

    // Hold the input until every predicted byte has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        byte_q_t  q;
        int       ntok;
        int       sel;
        int       cut;
        int       ndig;
        int       next_drain;
        logic [7:0]  b;
        logic [15:0] cp;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: byte extremes, escapes, UTF-8 extremes, bad and cut-off escapes
        send_string('{8'h00, 8'hFF});
        send_string('{CH_BACKSLASH, CH_N, CH_BACKSLASH, 8'h71, CH_BACKSLASH, CH_BACKSLASH});
        q = {};
        append_unicode(q, 16'h07FF);
        send_string(q);
        q = {};
        append_unicode(q, 16'hFFFF);
        send_string(q);
        send_string('{CH_BACKSLASH, CH_U, CH_ZERO + 8'd1, 8'h47});
        send_string('{CH_BACKSLASH});
        send_string('{CH_BACKSLASH, CH_U});
        send_string('{CH_BACKSLASH, CH_U, CH_ZERO + 8'd1, CH_ZERO + 8'd2});
        drain();

        // Random strings: mostly well-formed escapes, some broken ones
        next_drain = bytes_sent + DRAIN_EVERY;
        while (bytes_sent < RANDOM_BYTES) begin
            q = {};
            ntok = $urandom_range(1, 6);
            for (int t = 0; t < ntok; t++) begin
                sel = $urandom_range(0, 99);
                if (sel < 40) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_BACKSLASH) b = 8'h20;
                    q.push_back(b);
                end else if (sel < 60) begin
                    q.push_back(CH_BACKSLASH);
                    case ($urandom_range(0, 6))
                        0: q.push_back(CH_B);
                        1: q.push_back(CH_F);
                        2: q.push_back(CH_N);
                        3: q.push_back(CH_R);
                        4: q.push_back(CH_T);
                        5: begin
                            b = 8'($urandom_range(0, 255));
                            if (b == CH_U) b = CH_BACKSLASH;
                            q.push_back(b);
                        end
                        default: q.push_back(CH_BACKSLASH);
                    endcase
                end else if (sel < 90) begin
                    case ($urandom_range(0, 5))
                        0: cp = 16'($urandom_range(16'h0000, 16'h007F));
                        1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                        3: begin
                            case ($urandom_range(0, 5))
                                0: cp = 16'h0000;
                                1: cp = 16'h007F;
                                2: cp = 16'h0080;
                                3: cp = 16'h07FF;
                                4: cp = 16'h0800;
                                default: cp = 16'hFFFF;
                            endcase
                        end
                        4: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
                        default: cp = 16'($urandom_range(0, 16'hFFFF));
                    endcase
                    append_unicode(q, cp);
                end else begin
                    // Bad hex digit after zero to three good ones
                    q.push_back(CH_BACKSLASH);
                    q.push_back(CH_U);
                    ndig = $urandom_range(0, 3);
                    repeat (ndig) q.push_back(hex_char(4'($urandom_range(0, 15)),
                                                       1'($urandom_range(0, 1))));
                    do begin
                        b = 8'($urandom_range(0, 255));
                    end while ((b >= CH_ZERO && b <= CH_NINE) ||
                               (b >= CH_LOWER_A && b <= CH_LOWER_F) ||
                               (b >= CH_UPPER_A && b <= CH_UPPER_F));
                    q.push_back(b);
                end
            end
            // Cut the string short now and then, or end it on a lone backslash
            if (q.size() > 1 && $urandom_range(0, 7) == 0) begin
                cut = $urandom_range(1, (q.size() - 1 < 3) ? q.size() - 1 : 3);
                repeat (cut) void'(q.pop_back());
            end else if ($urandom_range(0, 15) == 0) begin
                q.push_back(CH_BACKSLASH);
            end
            send_string(q);
            if (bytes_sent >= next_drain) begin
                drain();
                next_drain = bytes_sent + DRAIN_EVERY;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("sent %0d bytes in %0d strings; checked %0d output bytes, %0d of them errors",
                 bytes_sent, strings_sent, bytes_checked, errors_seen);
        if (fail_count == 0) begin
            $display("json_string_unescape_utf8_tb passed");
        end else begin
            $display("json_string_unescape_utf8_tb failed");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2_000_000;
        $display("json_string_unescape_utf8_tb failed");
        $finish;
    end

endmodule
